FILE: rtl/core/rcbs_pkg.sv
// ----------------------------------------------------------------------------
// rcbs_pkg: shared types and constants for the RC battery switch controller
// Holds the event, battery-state and mode codes, the register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package rcbs_pkg;

   // Field and register widths that do not vary.
   localparam int PULSE_W     = 8;
   localparam int CONFIRM_W   = 4;
   localparam int LEVEL_CFG_W = 10;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 3;

   // Event kind carried by each input item.
   typedef enum logic [1:0] {
      OP_PULSE      = 2'd0,
      OP_SAMPLE     = 2'd1,
      OP_DISCONNECT = 2'd2,
      OP_TICK       = 2'd3
   } op_type;

   // Aux battery state as reported.
   typedef enum logic [1:0] {
      BS_UNKNOWN = 2'd0,
      BS_BAD     = 2'd1,
      BS_WARN    = 2'd2,
      BS_OK      = 2'd3
   } bstate_type;

   // Switch mode requested by the RC channel.
   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_MAIN = 2'd1,
      MODE_AUX  = 2'd2,
      MODE_OFF  = 2'd3
   } mode_type;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_MIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_MAX     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MID_START     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_ABOVE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_COUNT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LEVEL     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_TOL    = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [PULSE_W-1:0]     RST_PULSE_MIN     = 8'd15;
   localparam logic [PULSE_W-1:0]     RST_PULSE_MAX     = 8'd42;
   localparam logic [PULSE_W-1:0]     RST_MID_START     = 8'd25;
   localparam logic [PULSE_W-1:0]     RST_HIGH_ABOVE    = 8'd32;
   localparam logic [CONFIRM_W-1:0]   RST_CONFIRM_COUNT = 4'd5;
   localparam logic [LEVEL_CFG_W-1:0] RST_MIN_LEVEL     = 10'd167;
   localparam logic [LEVEL_CFG_W-1:0] RST_STABLE_TOL    = 10'd2;

endpackage

FILE: rtl/core/rcbs_req_if.sv
// ----------------------------------------------------------------------------
// rcbs_req_if: input event channel
// Valid/ready channel carrying one event item: its kind, an RC pulse width and
// an aux battery sample.
// ----------------------------------------------------------------------------
interface rcbs_req_if #(
   parameter int SAMPLE_BITS = 10
);
   import rcbs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [1:0]             op;
   logic [PULSE_W-1:0]     pulse_width;
   logic [SAMPLE_BITS-1:0] voltage_sample;

   modport source (output valid, output op, output pulse_width, output voltage_sample,
                   input ready);
   modport sink   (input valid, input op, input pulse_width, input voltage_sample,
                   output ready);
endinterface

FILE: rtl/core/rcbs_rsp_if.sv
// ----------------------------------------------------------------------------
// rcbs_rsp_if: result channel
// Valid/ready channel carrying one result item: the switch outputs and the
// battery and mode status.
// ----------------------------------------------------------------------------
interface rcbs_rsp_if;
   logic       valid;
   logic       ready;
   logic       aux_selected;
   logic       supply_on;
   logic       warn_led_on;
   logic [1:0] battery_state;
   logic [1:0] mode_applied;

   modport source (output valid, output aux_selected, output supply_on,
                   output warn_led_on, output battery_state, output mode_applied,
                   input ready);
   modport sink   (input valid, input aux_selected, input supply_on,
                   input warn_led_on, input battery_state, input mode_applied,
                   output ready);
endinterface

FILE: rtl/core/rc_battery_switch_controller.sv
// ----------------------------------------------------------------------------
// rc_battery_switch_controller
// Switches a load between main and aux battery and gates the 12V supply from
// RC pulse widths, and tracks the aux battery state from ADC samples.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake      | Contents
//  --------+-----------+----------------+---------------------------------------
//  req     | in        | valid / ready  | op, pulse_width, voltage_sample
//  rsp     | out       | valid / ready  | aux_selected, supply_on, warn_led_on,
//          |           |                | battery_state, mode_applied
//  csr     | in        | csr_wr_en      | csr_index, csr_wdata (write only)
//
//  One item per cycle sustained while rsp keeps taking results; an item's result
//  passes the input register, then the result register, before it can be taken.
//  The sample window, collapse and stability checks and the divide by three are
//  done in front of the input register; the level compares behind it.
//  Reset is synchronous and restores the default register values; no clearing
//  pass is needed, so the block takes items as soon as reset is released.
//  A stalled rsp holds the input register; req stalls only when both are full.
//
module rc_battery_switch_controller #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   rcbs_req_if.sink                            req,
   rcbs_rsp_if.source                          rsp,
   input  logic                                csr_wr_en,
   input  logic [rcbs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rcbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rcbs_pkg::*;

   // Widths derived from the sample width.
   localparam int SW     = SAMPLE_BITS;
   localparam int LW     = (SW > LEVEL_CFG_W) ? SW : LEVEL_CFG_W;
   localparam int SUM_W  = SW + 2;
   localparam int K3     = SUM_W + 2;
   localparam int DIV3_M = ((2 ** K3) + 2) / 3;
   localparam int X_W    = SW + 2;
   localparam int K5     = X_W + 2;
   localparam int DIV5_M = ((2 ** K5) + 4) / 5;

   // Configuration registers.
   logic [PULSE_W-1:0]     pmin_ff, pmax_ff, mid_ff, high_ff;
   logic [CONFIRM_W-1:0]   confirm_ff;
   logic [LEVEL_CFG_W-1:0] minlvl_ff, tol_ff;

   // Handshake and pipeline control.
   logic accept, advance;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Input register.
   op_type            s1_op_ff;
   logic [PULSE_W-1:0] s1_pulse_ff;
   logic              s1_collapse_ff, s1_collapse_in;
   logic              s1_stable_ff, s1_stable_in;
   logic [SW-1:0]     s1_avg_ff, s1_avg_in;

   // Sample window.
   logic [SW-1:0] hist0_ff, hist1_ff;
   logic [SW-1:0] smp_a, smp_hi, smp_lo;
   logic [SUM_W-1:0] smp_sum;
   logic [SUM_W+K3-2:0] prod3;

   // Controller state; the drive bits, battery state and mode double as the result register.
   mode_type             mode_ff, mode_in, pend_ff, pend_in;
   logic [CONFIRM_W-1:0] conf_ff, conf_in;
   bstate_type           bstate_ff, bstate_in;
   logic [LW-1:0]        fall_ff, fall_in;
   logic [SW-1:0]        warnlvl_ff, warnlvl_in;
   logic                 aux_ff, aux_in, supply_ff, supply_in, led_ff, led_in;

   // Behind the input register.
   logic [CONFIRM_W-1:0] confirm_load;
   logic                 pulse_bad;
   mode_type             want_mode;
   logic [SW-1:0]        fb_raw;
   logic [LW-1:0]        avg_l, fb_raw_l, minlvl_l;
   logic [SW:0]          warn_p1;
   logic [X_W+K5-2:0]    prod5;
   bstate_type           target;
   logic                 drive_upd;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pmin_ff    <= RST_PULSE_MIN;
         pmax_ff    <= RST_PULSE_MAX;
         mid_ff     <= RST_MID_START;
         high_ff    <= RST_HIGH_ABOVE;
         confirm_ff <= RST_CONFIRM_COUNT;
         minlvl_ff  <= RST_MIN_LEVEL;
         tol_ff     <= RST_STABLE_TOL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PULSE_MIN:     pmin_ff    <= csr_wdata[PULSE_W-1:0];
            CSR_PULSE_MAX:     pmax_ff    <= csr_wdata[PULSE_W-1:0];
            CSR_MID_START:     mid_ff     <= csr_wdata[PULSE_W-1:0];
            CSR_HIGH_ABOVE:    high_ff    <= csr_wdata[PULSE_W-1:0];
            CSR_CONFIRM_COUNT: confirm_ff <= csr_wdata[CONFIRM_W-1:0];
            CSR_MIN_LEVEL:     minlvl_ff  <= csr_wdata[LEVEL_CFG_W-1:0];
            CSR_STABLE_TOL:    tol_ff     <= csr_wdata[LEVEL_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the input register moves on when the result register is free
   // or being emptied in the same cycle.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready    = !s1_valid_ff || advance;
   assign accept       = req.valid && req.ready;
   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // Window of the newest three samples: zero counts as one.
   assign minlvl_l = LW'(minlvl_ff);
   always_comb begin
      smp_a = (req.voltage_sample == '0) ? SW'(1) : req.voltage_sample;
      smp_hi = (smp_a > hist0_ff) ? smp_a : hist0_ff;
      if (hist1_ff > smp_hi) begin
         smp_hi = hist1_ff;
      end
      smp_lo = (smp_a < hist0_ff) ? smp_a : hist0_ff;
      if (hist1_ff < smp_lo) begin
         smp_lo = hist1_ff;
      end
      s1_collapse_in = LW'(smp_hi) < (minlvl_l >> 1);
      s1_stable_in   = LW'(smp_hi - smp_lo) <= LW'(tol_ff);
      smp_sum        = SUM_W'(smp_a) + SUM_W'(hist0_ff) + SUM_W'(hist1_ff);
   end

   // Divide the sum by three with a reciprocal multiply.
   assign prod3     = (SUM_W + K3 - 1)'(smp_sum) * (SUM_W + K3 - 1)'(DIV3_M);
   assign s1_avg_in = prod3[K3 +: SW];

   // Input register and sample history.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         hist0_ff    <= '0;
         hist1_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept && (op_type'(req.op) == OP_SAMPLE)) begin
            hist1_ff <= hist0_ff;
            hist0_ff <= smp_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= op_type'(req.op);
         s1_pulse_ff    <= req.pulse_width;
         s1_collapse_ff <= s1_collapse_in;
         s1_stable_ff   <= s1_stable_in;
         s1_avg_ff      <= s1_avg_in;
      end
   end

   // Pulse classification; a confirm count of zero acts as one.
   assign confirm_load = (confirm_ff == '0) ? CONFIRM_W'(1) : confirm_ff;
   assign pulse_bad    = (s1_pulse_ff < pmin_ff) || (s1_pulse_ff > pmax_ff);
   assign want_mode    = (s1_pulse_ff > high_ff) ? MODE_OFF :
                         ((s1_pulse_ff >= mid_ff) ? MODE_AUX : MODE_MAIN);

   // Levels latched from the first stable reading: 75 % (at least the minimum level) and 80 %.
   assign avg_l    = LW'(s1_avg_ff);
   assign fb_raw   = s1_avg_ff - (s1_avg_ff >> 2);
   assign fb_raw_l = LW'(fb_raw);
   assign prod5    = (X_W + K5 - 1)'({s1_avg_ff, 2'b00}) * (X_W + K5 - 1)'(DIV5_M);
   assign warn_p1  = (SW + 1)'(warnlvl_ff) + (SW + 1)'(1);

   // Next controller state for the item in the input register.
   always_comb begin
      mode_in    = mode_ff;
      pend_in    = pend_ff;
      conf_in    = conf_ff;
      bstate_in  = bstate_ff;
      fall_in    = fall_ff;
      warnlvl_in = warnlvl_ff;
      aux_in     = aux_ff;
      supply_in  = supply_ff;
      led_in     = led_ff;
      target     = bstate_ff;
      drive_upd  = 1'b0;
      if (advance) begin
         unique case (s1_op_ff)
            OP_PULSE: begin
               // A missing measurement is ignored; an out-of-range one only
               // restarts a countdown that is already running.
               if (s1_pulse_ff != '0) begin
                  if (pulse_bad) begin
                     if (conf_ff != '0) begin
                        conf_in = confirm_load;
                     end
                  end else if (want_mode == pend_ff) begin
                     if (conf_ff != '0) begin
                        conf_in = conf_ff - CONFIRM_W'(1);
                        if (conf_ff == CONFIRM_W'(1)) begin
                           mode_in   = pend_ff;
                           drive_upd = 1'b1;
                        end
                     end
                  end else begin
                     pend_in = want_mode;
                     conf_in = confirm_load;
                  end
               end
            end
            OP_SAMPLE: begin
               if (s1_collapse_ff) begin
                  target     = BS_BAD;
                  fall_in    = '0;
                  warnlvl_in = '0;
               end else if (s1_stable_ff) begin
                  priority if (avg_l < minlvl_l) begin
                     target = BS_BAD;
                  end else if (fall_ff == '0) begin
                     fall_in    = (fb_raw_l > minlvl_l) ? fb_raw_l : minlvl_l;
                     warnlvl_in = prod5[K5 +: SW];
                  end else if (avg_l <= fall_ff) begin
                     target = BS_BAD;
                  end else if (s1_avg_ff <= warnlvl_ff) begin
                     target = BS_WARN;
                  end else if ((SW + 1)'(s1_avg_ff) > warn_p1) begin
                     target = BS_OK;
                  end else if ((bstate_ff == BS_UNKNOWN) || (bstate_ff == BS_BAD)) begin
                     target = BS_OK;
                  end else begin
                     target = bstate_ff;
                  end
               end
            end
            OP_DISCONNECT: begin
               target = BS_BAD;
            end
            OP_TICK: begin
               if (bstate_ff == BS_WARN) begin
                  led_in = !led_ff;
               end
            end
            default: ;
         endcase

         if (target != bstate_ff) begin
            bstate_in = target;
            drive_upd = 1'b1;
         end

         // Switch and LED drive follow a new mode or a new battery state.
         if (drive_upd) begin
            if (mode_in == MODE_OFF) begin
               aux_in    = 1'b0;
               supply_in = 1'b0;
            end else if ((mode_in == MODE_AUX) &&
                         ((bstate_in == BS_WARN) || (bstate_in == BS_OK))) begin
               aux_in    = 1'b1;
               supply_in = 1'b1;
            end else begin
               aux_in    = 1'b0;
               supply_in = 1'b1;
            end
            if (bstate_in == BS_OK) begin
               led_in = 1'b0;
            end else if (bstate_in != BS_WARN) begin
               led_in = 1'b1;
            end
         end
      end
   end

   // Controller state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_NONE;
         pend_ff      <= MODE_NONE;
         conf_ff      <= '0;
         bstate_ff    <= BS_UNKNOWN;
         fall_ff      <= '0;
         warnlvl_ff   <= '0;
         aux_ff       <= 1'b0;
         supply_ff    <= 1'b1;
         led_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         pend_ff      <= pend_in;
         conf_ff      <= conf_in;
         bstate_ff    <= bstate_in;
         fall_ff      <= fall_in;
         warnlvl_ff   <= warnlvl_in;
         aux_ff       <= aux_in;
         supply_ff    <= supply_in;
         led_ff       <= led_in;
      end
   end

   // The state only moves when a result is loaded, so it is the result item.
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.aux_selected  = aux_ff;
   assign rsp.supply_on     = supply_ff;
   assign rsp.warn_led_on   = led_ff;
   assign rsp.battery_state = bstate_ff;
   assign rsp.mode_applied  = mode_ff;

   // Once a mode has been applied there is always one.
   a_mode_sticks: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_NONE) |=> (mode_ff != MODE_NONE))
      else $error("applied mode went back to none");

   // A result waiting to be taken must not change under the consumer.
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=>
         ($stable(bstate_ff) && $stable(mode_ff) && $stable(led_ff) && $stable(aux_ff)))
      else $error("status changed while a result item was stalled");

   // The aux battery is only selected in aux mode with a usable battery.
   a_aux_needs_mode: assert property (@(posedge clock) disable iff (reset)
      aux_ff |-> ((mode_ff == MODE_AUX) && ((bstate_ff == BS_WARN) || (bstate_ff == BS_OK))
                  && supply_ff))
      else $error("aux selected outside aux mode or with a bad battery");

   // The 12V supply is off exactly in 12V-off mode once the drive has caught up.
   a_supply_off_mode: assert property (@(posedge clock) disable iff (reset)
      !supply_ff |-> (mode_ff == MODE_OFF))
      else $error("supply off while not in 12V-off mode");

endmodule
